// ===== design/cxs_pkg.sv =====
// Shared constants for the CIE xy to sRGB8 core: fixed-point formats,
// matrix coefficients and the sRGB curve threshold table.
// No dependencies.
package cxs_pkg;

  localparam int GAMMA_INDEX_BITS_DEF   = 12;
  localparam int QUOTIENT_FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC              = 14;

  localparam logic [7:0]  GREY_LEVEL    = 8'h20;
  localparam logic [15:0] SMALL_Y_LIMIT = 16'd6;

  // XYZ to linear sRGB, signed Q4.14, sign folded in
  localparam logic signed [17:0] K_RX = 18'sd53094;
  localparam logic signed [17:0] K_RY = -18'sd25185;
  localparam logic signed [17:0] K_RZ = -18'sd8169;
  localparam logic signed [17:0] K_GX = -18'sd15874;
  localparam logic signed [17:0] K_GY = 18'sd30733;
  localparam logic signed [17:0] K_GZ = 18'sd680;
  localparam logic signed [17:0] K_BX = 18'sd913;
  localparam logic signed [17:0] K_BY = -18'sd3342;
  localparam logic signed [17:0] K_BZ = 18'sd17318;

  localparam longint unsigned LIN_DEN  = 64'd658920;
  localparam longint unsigned GAMA_DEN = 64'd53805;

  typedef logic [32:0] thr_tab_t [256];

  function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
    return (a * b) >> 32;
  endfunction

  // Q32 threshold at which the 8-bit code steps to j
  function automatic logic [32:0] curve_thr(int j);
    longint unsigned n, p, a, a2, root, t, t2, t5;
    n = 0; p = 0; a = 0; a2 = 0; root = 0;
    if (j == 0) return 33'd0;
    if (j <= 10) begin
      n = longint'(2 * j - 1) * 64'd100 << 32;
      return 33'((n + LIN_DEN - 64'd1) / LIN_DEN);
    end
    p    = longint'(200 * j + 2705);
    a    = (p << 32) / GAMA_DEN;
    a2   = mul_q32(a, a);
    root = 0;
    for (int bit_i = 31; bit_i >= 0; bit_i--) begin
      t  = root | (64'd1 << bit_i);
      t2 = mul_q32(t, t);
      t5 = mul_q32(mul_q32(t2, t2), t);
      if (t5 <= a2) root = t;
    end
    return 33'(mul_q32(a2, root));
  endfunction

  function automatic thr_tab_t build_thr_tab();
    thr_tab_t tab;
    for (int j = 0; j < 256; j++) tab[j] = curve_thr(j);
    return tab;
  endfunction

  localparam thr_tab_t SRGB_THR = build_thr_tab();

endpackage

// ===== design/cie_xy_to_srgb8_core.sv =====
// CIE xy chromaticity to 8-bit sRGB, fully pipelined.
// Depends on cxs_pkg, cxs_div, cxs_mtx, cxs_gam.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one x, y pair per
//   transaction; output channel (out_valid_o / out_stall_i) carries the
//   red, green, blue codes and the fallback flag.
//   One transaction enters per cycle unless the output stalls; every input
//   yields exactly one result. Each passes through the two bit-per-stage
//   dividers (x/y and (1-x-y)/y), the matrix stages, the normalizing
//   dividers and the 8-step gamma search.
//   y_chroma of 6 or less gives grey 0x20 on all channels with fallback set.
//   The whole pipeline advances as one: while out_valid_o is high and
//   out_stall_i is high every stage holds, and in_stall_o is raised in the
//   same cycle. Empty slots fill up freely, so no transaction is lost or
//   repeated.
//   Reset clears all valid bits; payload registers are not reset.
module cie_xy_to_srgb8_core import cxs_pkg::*; #(
  parameter int GAMMA_INDEX_BITS   = GAMMA_INDEX_BITS_DEF,
  parameter int QUOTIENT_FRAC_BITS = QUOTIENT_FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] x_chroma_i,
  input  logic [15:0] y_chroma_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic        fallback_o
);

  localparam int F   = QUOTIENT_FRAC_BITS;
  localparam int G   = GAMMA_INDEX_BITS;
  localparam int QW  = 14 + F;
  localparam int CW  = QW + 7;
  localparam int NW2 = CW + G + 1;
  localparam int LAT = QW + 3 + (G + 1) + 8;

  logic           adv;
  logic [16:0]    zsum;
  logic           zneg;
  logic [15:0]    zmag;
  logic [QW-1:0]  cx, cz;
  logic [QW-1:0]  zneg_q;
  logic [CW-1:0]  lr, lg, lb, den;
  logic [NW2-1:0] num_r, num_g, num_b;
  logic [G:0]     idx_r, idx_g, idx_b;
  logic [7:0]     code_r, code_g, code_b;
  logic [LAT-1:0] vld_q, fb_q;

  // The pipeline moves unless a finished result is being held back
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // 1 - x - y in units of 65535, as sign and magnitude
  always_comb begin
    zsum = 17'(x_chroma_i) + 17'(y_chroma_i);
    zneg = zsum > 17'd65535;
    zmag = zneg ? 16'(zsum - 17'd65535) : 16'(17'd65535 - zsum);
  end

  cxs_div #(.NW(16 + F), .DW(16), .QW(QW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({x_chroma_i, F'(0)}),
    .den_i (y_chroma_i),
    .quo_o (cx)
  );

  cxs_div #(.NW(16 + F), .DW(16), .QW(QW)) u_div_z (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i ({zmag, F'(0)}),
    .den_i (y_chroma_i),
    .quo_o (cz)
  );

  // Carry the sign of Z alongside its quotient
  always_ff @(posedge clk_i) begin
    if (adv) zneg_q <= {zneg_q[QW-2:0], zneg};
  end

  cxs_mtx #(.F(F), .QW(QW), .CW(CW)) u_mtx (
    .clk_i   (clk_i),
    .en_i    (adv),
    .cx_i    (cx),
    .cz_i    (cz),
    .czneg_i (zneg_q[QW-1]),
    .lr_o    (lr),
    .lg_o    (lg),
    .lb_o    (lb),
    .den_o   (den)
  );

  // Rounded normalization: (c * 2^G + den/2) / den
  always_comb begin
    num_r = (NW2'(lr) << G) + NW2'(den >> 1);
    num_g = (NW2'(lg) << G) + NW2'(den >> 1);
    num_b = (NW2'(lb) << G) + NW2'(den >> 1);
  end

  cxs_div #(.NW(NW2), .DW(CW), .QW(G + 1)) u_div_r (
    .clk_i (clk_i), .en_i (adv), .num_i (num_r), .den_i (den), .quo_o (idx_r)
  );
  cxs_div #(.NW(NW2), .DW(CW), .QW(G + 1)) u_div_g (
    .clk_i (clk_i), .en_i (adv), .num_i (num_g), .den_i (den), .quo_o (idx_g)
  );
  cxs_div #(.NW(NW2), .DW(CW), .QW(G + 1)) u_div_b (
    .clk_i (clk_i), .en_i (adv), .num_i (num_b), .den_i (den), .quo_o (idx_b)
  );

  cxs_gam #(.G(G)) u_gam_r (.clk_i(clk_i), .en_i(adv), .idx_i(idx_r), .code_o(code_r));
  cxs_gam #(.G(G)) u_gam_g (.clk_i(clk_i), .en_i(adv), .idx_i(idx_g), .code_o(code_g));
  cxs_gam #(.G(G)) u_gam_b (.clk_i(clk_i), .en_i(adv), .idx_i(idx_b), .code_o(code_b));

  // Valid and fallback flags travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      fb_q  <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
      fb_q  <= {fb_q[LAT-2:0], y_chroma_i <= SMALL_Y_LIMIT};
    end
  end

  assign out_valid_o = vld_q[LAT-1];
  assign fallback_o  = fb_q[LAT-1];
  assign red_o       = fb_q[LAT-1] ? GREY_LEVEL : code_r;
  assign green_o     = fb_q[LAT-1] ? GREY_LEVEL : code_g;
  assign blue_o      = fb_q[LAT-1] ? GREY_LEVEL : code_b;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result waiting");

  a_shift_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> vld_q[LAT-1:1] == $past(vld_q[LAT-2:0]))
    else $error("valid bits did not advance with the pipeline");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vld_q) && $stable(fb_q))
    else $error("pipeline flags moved during a stall");

endmodule

// ===== design/cxs_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; caller guarantees the quotient fits in QW bits.
module cxs_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = 30
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in, den_in;
    logic [QW-1:0] low_in, quo_in;
    logic [DW:0]   trial, diff;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign low_in = low_q[i-1];
      assign quo_in = quo_q[i-1];
      assign den_in = den_q[i-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QW-1-i]};
      diff  = trial - {1'b0, den_in};
    end

    // advance one quotient bit
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, den_in}) begin
          rem_q[i] <= diff[DW-1:0];
          quo_q[i] <= quo_in | (QW'(1) << (QW-1-i));
        end else begin
          rem_q[i] <= trial[DW-1:0];
          quo_q[i] <= quo_in;
        end
        low_q[i] <= low_in;
        den_q[i] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// ===== design/cxs_mtx.sv =====
// XYZ to linear sRGB matrix, clamp, round and largest-channel pick; 3 stages.
// Depends on cxs_pkg.
module cxs_mtx import cxs_pkg::*; #(
  parameter int F  = QUOTIENT_FRAC_BITS_DEF,
  parameter int QW = 14 + F,
  parameter int CW = QW + 7
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] cx_i,
  input  logic [QW-1:0] cz_i,
  input  logic          czneg_i,
  output logic [CW-1:0] lr_o,
  output logic [CW-1:0] lg_o,
  output logic [CW-1:0] lb_o,
  output logic [CW-1:0] den_o
);

  localparam int PW = QW + 19;
  localparam int MW = PW + 2;
  localparam logic signed [MW-1:0] RY = MW'(K_RY) <<< F;
  localparam logic signed [MW-1:0] GY = MW'(K_GY) <<< F;
  localparam logic signed [MW-1:0] BY = MW'(K_BY) <<< F;
  localparam logic [CW-1:0] ONE = CW'(1) << F;

  function automatic logic [CW-1:0] to_lin(logic signed [MW-1:0] s);
    logic [MW-1:0] t;
    t = $unsigned(s) + (MW'(1) << (COEF_FRAC - 1));
    if (s[MW-1]) return '0;
    return CW'(t >> COEF_FRAC);
  endfunction

  logic signed [QW:0]   cxs, czs;
  logic signed [PW-1:0] p_q [6];
  logic [CW-1:0]        lin_q [3];
  logic [CW-1:0]        mx;
  logic [CW-1:0]        lr_q, lg_q, lb_q, den_q;

  always_comb begin
    cxs = {1'b0, cx_i};
    czs = czneg_i ? -$signed({1'b0, cz_i}) : $signed({1'b0, cz_i});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= cxs * K_RX;
      p_q[1] <= czs * K_RZ;
      p_q[2] <= cxs * K_GX;
      p_q[3] <= czs * K_GZ;
      p_q[4] <= cxs * K_BX;
      p_q[5] <= czs * K_BZ;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q[0] <= to_lin(MW'(p_q[0]) + MW'(p_q[1]) + RY);
      lin_q[1] <= to_lin(MW'(p_q[2]) + MW'(p_q[3]) + GY);
      lin_q[2] <= to_lin(MW'(p_q[4]) + MW'(p_q[5]) + BY);
    end
  end

  always_comb begin
    mx = lin_q[0];
    if (lin_q[1] > mx) mx = lin_q[1];
    if (lin_q[2] > mx) mx = lin_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lr_q  <= lin_q[0];
      lg_q  <= lin_q[1];
      lb_q  <= lin_q[2];
      den_q <= (mx > ONE) ? mx : ONE;
    end
  end

  assign lr_o  = lr_q;
  assign lg_o  = lg_q;
  assign lb_o  = lb_q;
  assign den_o = den_q;

endmodule

// ===== design/cxs_gam.sv =====
// sRGB gamma encode: 8-stage binary search over the threshold table.
// Depends on cxs_pkg.
module cxs_gam import cxs_pkg::*; #(
  parameter int G = GAMMA_INDEX_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [G:0] idx_i,
  output logic [7:0] code_o
);

  logic [32:0] v_q    [8];
  logic [7:0]  code_q [8];

  for (genvar s = 0; s < 8; s++) begin : g_step
    logic [32:0] v_in;
    logic [7:0]  code_in, cand;

    if (s == 0) begin : g_first
      assign v_in    = 33'(idx_i) << (32 - G);
      assign code_in = '0;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign code_in = code_q[s-1];
    end

    assign cand = code_in | (8'd1 << (7 - s));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[s]    <= v_in;
        code_q[s] <= (v_in >= SRGB_THR[cand]) ? cand : code_in;
      end
    end
  end

  assign code_o = code_q[7];

endmodule

// ===== sim/tb_cie_xy_to_srgb8_core.sv =====
// Self-checking testbench for cie_xy_to_srgb8_core: directed chromaticity
// table, then random pairs under several idle/stall mixes.
// Depends on cxs_pkg and the design sources only.
`timescale 1ns / 1ps

module tb_cie_xy_to_srgb8_core;
  import cxs_pkg::*;

  localparam int IDX_BITS    = 12;
  localparam int QFRAC       = 16;
  localparam int N_RANDOM    = 750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       fallback;
  } srgb_px_t;

  typedef struct {
    logic [15:0] x;
    logic [15:0] y;
    bit          typed;   // expected value written in by hand
    srgb_px_t    px;
  } xy_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] x_chroma_i = '0;
  logic [15:0] y_chroma_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  red_o, green_o, blue_o;
  logic        fallback_o;

  // sRGB code step points, Q32 of linear light
  longint unsigned srgb_step [256];
  srgb_px_t        pending_px [$];
  srgb_px_t        next_px;
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              n_errors = 0;
  int              n_results = 0;
  int              n_fallback = 0;
  int              cycle_cnt = 0;

  cie_xy_to_srgb8_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_chroma_i  (x_chroma_i),
    .y_chroma_i  (y_chroma_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .fallback_o  (fallback_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop if the pipeline wedges
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_cnt,
               pending_px.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint unsigned q32_mul(longint unsigned a, longint unsigned b);
    return (a * b) >> 32;
  endfunction

  // Linear segment below code 11, power segment above: a^2.4 via a^2 * a^0.4
  function automatic void fill_srgb_steps();
    longint unsigned num, base, base_sq, root, trial, t2, t5;
    srgb_step[0] = 0;
    for (int j = 1; j < 256; j++) begin
      if (j <= 10) begin
        num = (longint'(2 * j - 1) * 64'd100) << 32;
        srgb_step[j] = (num + 64'd658919) / 64'd658920;
      end else begin
        base    = (longint'(200 * j + 2705) << 32) / 64'd53805;
        base_sq = q32_mul(base, base);
        root    = 0;
        for (int b = 31; b >= 0; b--) begin
          trial = root | (64'd1 << b);
          t2    = q32_mul(trial, trial);
          t5    = q32_mul(q32_mul(t2, t2), trial);
          if (t5 <= base_sq) root = trial;
        end
        srgb_step[j] = q32_mul(base_sq, root);
      end
    end
  endfunction

  function automatic longint clip_quotient(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (num << QFRAC) / den;
    if (q > (64'd1 << (14 + QFRAC)) - 1) q = (64'd1 << (14 + QFRAC)) - 1;
    return longint'(q);
  endfunction

  // Drop negatives, round Q.(F+14) down to Q.F
  function automatic longint unsigned lin_round(longint v);
    if (v <= 0) return 0;
    return (longint'(v) + (64'd1 << 13)) >> 14;
  endfunction

  function automatic logic [7:0] gamma_code(longint unsigned c, longint unsigned den);
    longint unsigned idx, pos;
    logic [7:0]      code;
    idx  = ((c << IDX_BITS) + den / 2) / den;
    pos  = idx << (32 - IDX_BITS);
    code = 0;
    for (int j = 1; j < 256; j++)
      if (pos >= srgb_step[j]) code = j[7:0];
    return code;
  endfunction

  function automatic srgb_px_t xy_to_srgb(logic [15:0] x, logic [15:0] y);
    srgb_px_t        px;
    longint          qx, qz, qy, zn, rs, gs, bs;
    longint unsigned lr, lg, lb, den;
    if (y <= SMALL_Y_LIMIT) begin
      px = '{red: GREY_LEVEL, green: GREY_LEVEL, blue: GREY_LEVEL, fallback: 1'b1};
      return px;
    end
    qx = clip_quotient(x, y);
    zn = 65535 - longint'(x) - longint'(y);
    qz = (zn < 0) ? -clip_quotient(-zn, y) : clip_quotient(zn, y);
    qy = 64'sd1 << QFRAC;
    rs = 53094 * qx - 25185 * qy - 8169 * qz;
    gs = -15874 * qx + 30733 * qy + 680 * qz;
    bs = 913 * qx - 3342 * qy + 17318 * qz;
    lr = lin_round(rs);
    lg = lin_round(gs);
    lb = lin_round(bs);
    den = 64'd1 << QFRAC;
    if (lr > den) den = lr;
    if (lg > den) den = lg;
    if (lb > den) den = lb;
    px.red      = gamma_code(lr, den);
    px.green    = gamma_code(lg, den);
    px.blue     = gamma_code(lb, den);
    px.fallback = 1'b0;
    return px;
  endfunction

  // Present one pair; hold it until the core takes it, then book the result
  task automatic drive_pair(logic [15:0] x, logic [15:0] y, srgb_px_t px);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_chroma_i <= x;
    y_chroma_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_px.push_back(px);
  endtask

  // Receive side: compare every transaction, then pick the next stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (fallback_o) n_fallback++;
      if (pending_px.size() == 0) begin
        $display("%0t: unexpected result r=%02h g=%02h b=%02h fb=%0b", $time,
                 red_o, green_o, blue_o, fallback_o);
        n_errors++;
      end else begin
        next_px = pending_px.pop_front();
        if (next_px.red !== red_o) begin
          $display("%0t: red exp %02h got %02h", $time, next_px.red, red_o);
          n_errors++;
        end
        if (next_px.green !== green_o) begin
          $display("%0t: green exp %02h got %02h", $time, next_px.green, green_o);
          n_errors++;
        end
        if (next_px.blue !== blue_o) begin
          $display("%0t: blue exp %02h got %02h", $time, next_px.blue, blue_o);
          n_errors++;
        end
        if (next_px.fallback !== fallback_o) begin
          $display("%0t: fallback exp %0b got %0b", $time, next_px.fallback,
                   fallback_o);
          n_errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    xy_row_t    rows [$];
    srgb_px_t   grey;
    logic [15:0] rx, ry;
    int         sel;

    fill_srgb_steps();
    grey = '{red: GREY_LEVEL, green: GREY_LEVEL, blue: GREY_LEVEL, fallback: 1'b1};

    // Small y hands back fixed grey; everything else goes through the predictor
    rows.push_back('{16'd0,     16'd0,     1'b1, grey});
    rows.push_back('{16'd65535, 16'd0,     1'b1, grey});
    rows.push_back('{16'd0,     16'd1,     1'b1, grey});
    rows.push_back('{16'd65535, 16'd6,     1'b1, grey});
    rows.push_back('{16'd32768, 16'd6,     1'b1, grey});
    rows.push_back('{16'd0,     16'd7,     1'b0, grey});  // largest Z
    rows.push_back('{16'd65535, 16'd7,     1'b0, grey});  // largest X
    rows.push_back('{16'd65528, 16'd7,     1'b0, grey});  // x + y at one
    rows.push_back('{16'd65535, 16'd65535, 1'b0, grey});  // x + y far above one
    rows.push_back('{16'd0,     16'd65535, 1'b0, grey});
    rows.push_back('{16'd65535, 16'd1000,  1'b0, grey});  // negative Z
    rows.push_back('{16'd21469, 16'd22589, 1'b0, grey});  // near white point
    rows.push_back('{16'd41943, 16'd21627, 1'b0, grey});  // red primary
    rows.push_back('{16'd19661, 16'd39322, 1'b0, grey});  // green primary
    rows.push_back('{16'd9830,  16'd3932,  1'b0, grey});  // blue primary
    rows.push_back('{16'd10000, 16'd50000, 1'b0, grey});
    rows.push_back('{16'd1,     16'd65534, 1'b0, grey});
    rows.push_back('{16'd43690, 16'd21845, 1'b0, grey});
    rows.push_back('{16'd200,   16'd300,   1'b0, grey});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run back to back with the receiver always ready
    foreach (rows[i])
      drive_pair(rows[i].x, rows[i].y,
                 rows[i].typed ? rows[i].px : xy_to_srgb(rows[i].x, rows[i].y));

    for (int k = 0; k < N_RANDOM; k++) begin
      // Rotate through the pressure mixes, one quarter each
      case (k * 4 / N_RANDOM)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      sel = $urandom_range(99);
      if (sel < 60) begin
        // Inside the visible gamut, roughly
        rx = 16'($urandom_range(50000));
        ry = 16'($urandom_range(60000, 2000));
      end else if (sel < 85) begin
        rx = 16'($urandom);
        ry = 16'($urandom);
      end else if (sel < 95) begin
        rx = 16'($urandom);
        ry = 16'($urandom_range(12));
      end else begin
        rx = 16'($urandom_range(65535, 60000));
        ry = 16'($urandom_range(65535, 30000));
      end
      drive_pair(rx, ry, xy_to_srgb(rx, ry));
    end
    in_valid_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Ran %0d pairs (%0d directed), %0d results, %0d grey fallbacks,",
             rows.size() + N_RANDOM, rows.size(), n_results, n_fallback);
    $display("  under free-flow, sparse-input, heavy-stall and mixed pressure.");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
